// ===== src/chr_pkg.sv =====
// Shared types, constants and hash helpers for the consistent-hash ring router.
// No dependencies; imported by every module of the block.
package chr_pkg;

  localparam int NODE_SLOTS_DEF = 16;
  localparam int VNODES_MAX_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int VN_W           = 7;

  localparam logic [31:0]     FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0]     FNV_PRIME  = 32'd16777619;
  localparam logic [31:0]     MIX_C1     = 32'h85EBCA6B;
  localparam logic [31:0]     MIX_C2     = 32'hC2B2AE35;
  localparam logic [7:0]      HASH_CHAR  = 8'h23;
  localparam logic [3:0]      DIGIT_HI   = 4'h3;
  localparam logic [VN_W-1:0] VN_RESET   = 7'd16;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    B_IDLE, B_VH, B_MX1, B_MX2, B_MX3, B_SRD, B_SCMP, B_PCHK,
    B_SHRD, B_SHWR, B_INS, B_ADV, B_RESP, B_WRD, B_WCHK, B_FLUSH
  } back_st_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [3:0] node_slot;
    logic [4:0] replica_count;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        found;
    logic [3:0]  node;
    logic        last_result;
    logic [4:0]  node_total;
    logic [15:0] present_mask;
  } out_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] hash;
    logic [3:0]  slot;
    logic [4:0]  want;
  } job_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [3:0]  owner;
  } ring_ent_t;

  function automatic logic [31:0] fnv_byte(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

endpackage

// ===== src/consistent_hash_ring_router.sv =====
// Input: one byte per cycle while the queue has room; a non-final byte only updates the hash.
// Add/remove: each virtual node is hashed, binary-searched in the ring and then shifted in or
// out, with one ring memory access at a time.
// Lookup: mix the key hash, binary-search the ring, then walk it; one result per new owner found.
// Reset: ring count, slot mask, queue and output cleared at once; ring memory is not cleared.
// Virtual node count resets to 16.
module consistent_hash_ring_router #(
  parameter int NODE_SLOTS = chr_pkg::NODE_SLOTS_DEF,
  parameter int VNODES_MAX = chr_pkg::VNODES_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  chr_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output chr_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [chr_pkg::VN_W-1:0] cfg_wdata_i
);
  import chr_pkg::*;

  localparam int RING_CAP = NODE_SLOTS * VNODES_MAX;
  localparam int EW       = $clog2(RING_CAP + 1);

  logic [VN_W-1:0] vn_q;
  logic            push, full, q_valid, q_pop;
  job_t            push_job, q_job;
  logic [EW-1:0]   entries;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= VN_RESET;
    end else if (cfg_we_i) begin
      vn_q <= cfg_wdata_i;
    end
  end

  chr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .full_i(full), .push_o(push), .job_o(push_job)
  );

  chr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_job), .full_o(full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_job)
  );

  chr_back #(.NODE_SLOTS(NODE_SLOTS), .VNODES_MAX(VNODES_MAX)) u_back (
    .clk_i, .rst_ni, .vn_cfg_i(vn_q), .job_valid_i(q_valid), .job_i(q_job),
    .job_pop_o(q_pop), .out_stall_i, .out_valid_o, .out_data_o, .entries_o(entries)
  );

  a_entries_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(entries) <= RING_CAP) else $error("ring count above capacity");

  a_found_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      out_data_o.kind == CMD_LOOKUP && out_data_o.status == ST_OK)
    else $error("found set on a non-lookup transaction");

  a_total_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && NODE_SLOTS <= 16 |->
      32'(out_data_o.node_total) == $countones(out_data_o.present_mask))
    else $error("node total disagrees with present mask");

endmodule

// ===== src/chr_front.sv =====
// Front end: folds key/name bytes into the FNV-1a hash and issues a job on the last byte.
// Depends on chr_pkg.
module chr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  chr_pkg::in_t  in_data_i,
  input  logic          full_i,
  output logic          push_o,
  output chr_pkg::job_t job_o
);
  import chr_pkg::*;

  logic [31:0] hash_q, hash_d, h_upd;
  logic        live;

  assign in_stall_o = full_i;

  always_comb begin
    live = in_valid_i && !full_i &&
           (in_data_i.cmd == CMD_LOOKUP || in_data_i.cmd == CMD_ADD ||
            in_data_i.cmd == CMD_REMOVE);
    h_upd = in_data_i.byte_valid ? fnv_byte(hash_q, in_data_i.data_byte) : hash_q;
    hash_d = hash_q;
    if (live) begin
      hash_d = in_data_i.last_byte ? FNV_OFFSET : h_upd;
    end
    push_o     = live && in_data_i.last_byte;
    job_o.cmd  = cmd_e'(in_data_i.cmd);
    job_o.hash = h_upd;
    job_o.slot = in_data_i.node_slot;
    job_o.want = in_data_i.replica_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_OFFSET;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ===== src/chr_fifo.sv =====
// Short job queue between the byte front end and the ring sequencer.
// Depends on chr_pkg.
module chr_fifo #(
  parameter int DEPTH = chr_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  chr_pkg::job_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output chr_pkg::job_t data_o
);
  import chr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rptr_q + 1'b1);
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== src/chr_back.sv =====
// Back end: ring sequencer with sorted ring memory, vnode hashing, search, shift and walk.
// Depends on chr_pkg; holds the output register.
module chr_back #(
  parameter int NODE_SLOTS = chr_pkg::NODE_SLOTS_DEF,
  parameter int VNODES_MAX = chr_pkg::VNODES_MAX_DEF,
  localparam int RING_CAP  = NODE_SLOTS * VNODES_MAX,
  localparam int EW        = $clog2(RING_CAP + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [chr_pkg::VN_W-1:0] vn_cfg_i,
  input  logic                     job_valid_i,
  input  chr_pkg::job_t            job_i,
  output logic                     job_pop_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output chr_pkg::out_t            out_data_o,
  output logic [EW-1:0]            entries_o
);
  import chr_pkg::*;

  localparam int AW = $clog2(RING_CAP);
  localparam int VW = $clog2(VNODES_MAX + 1);
  localparam int CW = $clog2(NODE_SLOTS + 1);

  ring_ent_t ring_mem [RING_CAP];
  ring_ent_t rdata_q, mem_wdata;
  logic [AW-1:0] raddr, mem_waddr;
  logic rd_en, mem_we;

  back_st_e st_q, st_d;
  job_t job_q, job_d;
  logic [31:0] hw_q, hw_d, key_q, key_d;
  logic [EW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
  logic [EW-1:0] idx_q, idx_d, steps_q, steps_d, entries_q, entries_d;
  logic [EW-1:0] mid, jm1, jp1, idx_n, steps_n;
  logic [NODE_SLOTS-1:0] mask_q, mask_d, slot_bit;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] vi_q, vi_d, vn_q, vn_d, vn_used;
  logic [3:0] d0_q, d0_d, d1_q, d1_d, d2_q, d2_d, digit, own, pend_q, pend_d;
  logic [1:0] step_q, step_d, ndig, rsel;
  logic [4:0] k_q, k_d, want_q, want_d, k_n;
  logic [15:0] seen_q, seen_d, own_bit;
  logic pend_v_q, pend_v_d, newo, hit, can_load, out_load, out_valid_q;
  status_e res_status_q, res_status_d;
  out_t out_q, res;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign entries_o   = entries_q;

  always_comb begin
    can_load = !out_valid_q || !out_stall_i;
    slot_bit = NODE_SLOTS'(1) << job_q.slot;
    ndig = (d2_q != '0) ? 2'd3 : ((d1_q != '0) ? 2'd2 : 2'd1);
    rsel = ndig - step_q;
    digit = (rsel == 2'd0) ? d0_q : ((rsel == 2'd1) ? d1_q : d2_q);
    if (vn_cfg_i == '0) begin
      vn_used = VW'(1);
    end else if (32'(vn_cfg_i) > VNODES_MAX) begin
      vn_used = VW'(VNODES_MAX);
    end else begin
      vn_used = VW'(vn_cfg_i);
    end
    mid = lo_q + ((hi_q - lo_q) >> 1);
    jm1 = j_q - 1'b1;
    jp1 = j_q + 1'b1;
    own = rdata_q.owner;
    own_bit = 16'(1) << own;
    newo = !(|(seen_q & own_bit));
    hit = (lo_q < entries_q) && (rdata_q.pos == key_q);
    k_n = k_q + 5'(newo);
    steps_n = steps_q + 1'b1;
    idx_n = (32'(idx_q) + 1 >= 32'(entries_q)) ? '0 : EW'(idx_q + 1'b1);

    st_d = st_q; job_d = job_q; hw_d = hw_q; key_d = key_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; j_d = j_q;
    idx_d = idx_q; steps_d = steps_q; entries_d = entries_q;
    mask_d = mask_q; cnt_d = cnt_q; vi_d = vi_q; vn_d = vn_q;
    d0_d = d0_q; d1_d = d1_q; d2_d = d2_q; step_d = step_q;
    k_d = k_q; want_d = want_q; seen_d = seen_q;
    pend_d = pend_q; pend_v_d = pend_v_q; res_status_d = res_status_q;
    job_pop_o = 1'b0; rd_en = 1'b0; raddr = '0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    out_load = 1'b0; res = '0;

    unique case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d = job_i;
          if (job_i.cmd == CMD_LOOKUP) begin
            want_d = (32'(job_i.want) > 32'(cnt_q)) ? 5'(cnt_q) : job_i.want;
            if (entries_q == '0 || want_d == '0) begin
              res_status_d = ST_NONE;
              st_d = B_RESP;
            end else begin
              hw_d = job_i.hash; seen_d = '0; pend_v_d = 1'b0;
              k_d = '0; steps_d = '0;
              st_d = B_MX1;
            end
          end else if (32'(job_i.slot) >= NODE_SLOTS) begin
            res_status_d = ST_NONE;
            st_d = B_RESP;
          end else if (job_i.cmd == CMD_ADD &&
                       |(mask_q & (NODE_SLOTS'(1) << job_i.slot))) begin
            res_status_d = ST_DUP;
            st_d = B_RESP;
          end else begin
            res_status_d = ST_OK;
            vi_d = '0; d0_d = '0; d1_d = '0; d2_d = '0; step_d = '0;
            vn_d = vn_used;
            st_d = B_VH;
          end
        end
      end
      B_VH: begin
        if (step_q == 2'd0) begin
          hw_d = fnv_byte(job_q.hash, HASH_CHAR);
        end else begin
          hw_d = fnv_byte(hw_q, {DIGIT_HI, digit});
        end
        if (step_q == ndig) begin
          st_d = B_MX1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      B_MX1: begin
        hw_d = (hw_q ^ (hw_q >> 16)) * MIX_C1;
        st_d = B_MX2;
      end
      B_MX2: begin
        hw_d = (hw_q ^ (hw_q >> 13)) * MIX_C2;
        st_d = B_MX3;
      end
      B_MX3: begin
        key_d = hw_q ^ (hw_q >> 16);
        lo_d = '0;
        hi_d = entries_q;
        st_d = B_SRD;
      end
      B_SRD: begin
        if (lo_q < hi_q) begin
          mid_d = mid;
          rd_en = 1'b1;
          raddr = mid[AW-1:0];
          st_d = B_SCMP;
        end else if (job_q.cmd == CMD_LOOKUP) begin
          idx_d = (lo_q >= entries_q) ? '0 : lo_q;
          st_d = B_WRD;
        end else begin
          rd_en = 1'b1;
          raddr = lo_q[AW-1:0];
          st_d = B_PCHK;
        end
      end
      B_SCMP: begin
        if (rdata_q.pos < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        st_d = B_SRD;
      end
      B_PCHK: begin
        if (job_q.cmd == CMD_ADD) begin
          if (hit) begin
            mem_we = 1'b1; mem_waddr = lo_q[AW-1:0];
            mem_wdata = '{pos: key_q, owner: job_q.slot};
            st_d = B_ADV;
          end else if (entries_q >= EW'(RING_CAP)) begin
            st_d = B_ADV;
          end else begin
            j_d = entries_q;
            st_d = (entries_q == lo_q) ? B_INS : B_SHRD;
          end
        end else if (hit) begin
          j_d = lo_q;
          if (32'(lo_q) + 1 < 32'(entries_q)) begin
            st_d = B_SHRD;
          end else begin
            entries_d = entries_q - 1'b1;
            st_d = B_ADV;
          end
        end else begin
          st_d = B_ADV;
        end
      end
      B_SHRD: begin
        rd_en = 1'b1;
        raddr = (job_q.cmd == CMD_ADD) ? jm1[AW-1:0] : jp1[AW-1:0];
        st_d = B_SHWR;
      end
      B_SHWR: begin
        mem_we = 1'b1; mem_waddr = j_q[AW-1:0]; mem_wdata = rdata_q;
        if (job_q.cmd == CMD_ADD) begin
          if (jm1 == lo_q) begin
            st_d = B_INS;
          end else begin
            j_d = jm1;
            st_d = B_SHRD;
          end
        end else if (32'(jp1) + 1 < 32'(entries_q)) begin
          j_d = jp1;
          st_d = B_SHRD;
        end else begin
          entries_d = entries_q - 1'b1;
          st_d = B_ADV;
        end
      end
      B_INS: begin
        mem_we = 1'b1; mem_waddr = lo_q[AW-1:0];
        mem_wdata = '{pos: key_q, owner: job_q.slot};
        entries_d = entries_q + 1'b1;
        st_d = B_ADV;
      end
      B_ADV: begin
        if (32'(vi_q) + 1 >= 32'(vn_q)) begin
          st_d = B_RESP;
        end else begin
          vi_d = vi_q + 1'b1;
          step_d = '0;
          if (d0_q == 4'd9) begin
            d0_d = '0;
            if (d1_q == 4'd9) begin
              d1_d = '0;
              d2_d = d2_q + 1'b1;
            end else begin
              d1_d = d1_q + 1'b1;
            end
          end else begin
            d0_d = d0_q + 1'b1;
          end
          st_d = B_VH;
        end
      end
      B_RESP: begin
        if (can_load) begin
          out_load = 1'b1;
          if (job_q.cmd == CMD_ADD && res_status_q == ST_OK) begin
            mask_d = mask_q | slot_bit;
            cnt_d = cnt_q + 1'b1;
          end else if (job_q.cmd == CMD_REMOVE && res_status_q == ST_OK) begin
            mask_d = mask_q & ~slot_bit;
            cnt_d = cnt_q - CW'(|(mask_q & slot_bit));
          end
          res.kind = job_q.cmd;
          res.status = res_status_q;
          res.found = 1'b0;
          res.node = (job_q.cmd == CMD_LOOKUP) ? 4'd0 : job_q.slot;
          res.last_result = 1'b1;
          res.node_total = 5'(cnt_d);
          res.present_mask = 16'(mask_d);
          st_d = B_IDLE;
        end
      end
      B_WRD: begin
        rd_en = 1'b1;
        raddr = idx_q[AW-1:0];
        st_d = B_WCHK;
      end
      B_WCHK: begin
        if (!(newo && pend_v_q && !can_load)) begin
          if (newo) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              res.kind = CMD_LOOKUP; res.status = ST_OK; res.found = 1'b1;
              res.node = pend_q; res.last_result = 1'b0;
              res.node_total = 5'(cnt_q); res.present_mask = 16'(mask_q);
            end
            pend_d = own; pend_v_d = 1'b1;
            seen_d = seen_q | own_bit;
          end
          k_d = k_n; steps_d = steps_n; idx_d = idx_n;
          st_d = (k_n == want_q || steps_n == entries_q) ? B_FLUSH : B_WRD;
        end
      end
      B_FLUSH: begin
        if (can_load) begin
          out_load = 1'b1;
          res.kind = CMD_LOOKUP; res.status = ST_OK; res.found = 1'b1;
          res.node = pend_q; res.last_result = 1'b1;
          res.node_total = 5'(cnt_q); res.present_mask = 16'(mask_q);
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      entries_q <= '0;
      mask_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      entries_q <= entries_d;
      mask_q <= mask_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; hw_q <= hw_d; key_q <= key_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d; j_q <= j_d;
    idx_q <= idx_d; steps_q <= steps_d;
    vi_q <= vi_d; vn_q <= vn_d; d0_q <= d0_d; d1_q <= d1_d; d2_q <= d2_d;
    step_q <= step_d; k_q <= k_d; want_q <= want_d; seen_q <= seen_d;
    pend_q <= pend_d; pend_v_q <= pend_v_d; res_status_q <= res_status_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= ring_mem[raddr];
    end
  end

endmodule

// ===== tb/consistent_hash_ring_router_chk.sv =====
// Checker for the consistent-hash ring router: watches both channels and the config port,
// predicts results with its own ring model, and compares them. Depends on chr_pkg.
module consistent_hash_ring_router_chk
  import chr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  in_t             in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  out_t            out_data_i,
  input  logic            cfg_we_i,
  input  logic [VN_W-1:0] cfg_wdata_i,
  output int              fail_o,
  output int              pending_o,
  output int              checked_o
);

  localparam int RING_CAP = NODE_SLOTS_DEF * VNODES_MAX_DEF;
  localparam logic [7:0] DIGIT0 = 8'h30;

  logic [VN_W-1:0] vn_reg;
  logic [31:0]     key_hash;
  logic [31:0]     ring_pos [RING_CAP];
  logic [3:0]      ring_own [RING_CAP];
  int              ring_cnt;
  logic [15:0]     slot_mask;
  out_t            result_q[$];

  function automatic logic [31:0] fold(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] fmix(input logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * MIX_C1;
    h = h ^ (h >> 13);
    h = h * MIX_C2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic logic [31:0] vnode_hash(input logic [31:0] prefix, input int idx);
    logic [31:0] h;
    h = fold(prefix, HASH_CHAR);
    if (idx >= 10) h = fold(h, DIGIT0 + 8'(idx / 10));
    h = fold(h, DIGIT0 + 8'(idx % 10));
    return fmix(h);
  endfunction

  function automatic int first_at_or_above(input logic [31:0] h);
    int lo, hi, mid;
    lo = 0;
    hi = ring_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (ring_pos[mid] < h) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void ring_add(input logic [31:0] h, input logic [3:0] owner);
    int p;
    p = first_at_or_above(h);
    if (p < ring_cnt && ring_pos[p] == h) begin
      ring_own[p] = owner;
    end else if (ring_cnt < RING_CAP) begin
      for (int j = ring_cnt; j > p; j--) begin
        ring_pos[j] = ring_pos[j-1];
        ring_own[j] = ring_own[j-1];
      end
      ring_pos[p] = h;
      ring_own[p] = owner;
      ring_cnt++;
    end
  endfunction

  function automatic void ring_del(input logic [31:0] h);
    int p;
    p = first_at_or_above(h);
    if (p < ring_cnt && ring_pos[p] == h) begin
      for (int j = p; j < ring_cnt - 1; j++) begin
        ring_pos[j] = ring_pos[j+1];
        ring_own[j] = ring_own[j+1];
      end
      ring_cnt--;
    end
  endfunction

  function automatic out_t make_result(input logic [1:0] kind, input logic [1:0] status,
                                       input logic found, input logic [3:0] node,
                                       input logic lst);
    out_t r;
    r.kind = kind;
    r.status = status;
    r.found = found;
    r.node = node;
    r.last_result = lst;
    r.node_total = 5'($countones(slot_mask));
    r.present_mask = slot_mask;
    return r;
  endfunction

  function automatic void route_step(input in_t t);
    logic [31:0] h;
    int          vn, want, idx, k;
    logic [15:0] seen;
    out_t        walk [16];
    if (t.cmd != CMD_LOOKUP && t.cmd != CMD_ADD && t.cmd != CMD_REMOVE) return;
    if (t.byte_valid) key_hash = fold(key_hash, t.data_byte);
    if (!t.last_byte) return;
    h = key_hash;
    key_hash = FNV_OFFSET;
    if (t.cmd == CMD_ADD || t.cmd == CMD_REMOVE) begin
      if (t.cmd == CMD_ADD && slot_mask[t.node_slot]) begin
        result_q = {result_q, make_result(t.cmd, ST_DUP, 1'b0, t.node_slot, 1'b1)};
      end else begin
        vn = (vn_reg == 0) ? 1 : (vn_reg > VNODES_MAX_DEF) ? VNODES_MAX_DEF : int'(vn_reg);
        for (int i = 0; i < vn; i++) begin
          if (t.cmd == CMD_ADD) ring_add(vnode_hash(h, i), t.node_slot);
          else ring_del(vnode_hash(h, i));
        end
        slot_mask[t.node_slot] = (t.cmd == CMD_ADD);
        result_q = {result_q, make_result(t.cmd, ST_OK, 1'b0, t.node_slot, 1'b1)};
      end
      return;
    end
    want = int'(t.replica_count);
    if (want > $countones(slot_mask)) want = $countones(slot_mask);
    if (ring_cnt == 0 || want == 0) begin
      result_q = {result_q, make_result(CMD_LOOKUP, ST_NONE, 1'b0, 4'd0, 1'b1)};
      return;
    end
    idx = first_at_or_above(fmix(h));
    if (idx >= ring_cnt) idx = 0;
    seen = '0;
    k = 0;
    for (int steps = 0; steps < ring_cnt && k < want; steps++) begin
      if (!seen[ring_own[idx]]) begin
        seen[ring_own[idx]] = 1'b1;
        walk[k] = make_result(CMD_LOOKUP, ST_OK, 1'b1, ring_own[idx], 1'b0);
        k++;
      end
      idx = (idx + 1 >= ring_cnt) ? 0 : idx + 1;
    end
    walk[k-1].last_result = 1'b1;
    for (int i = 0; i < k; i++) result_q = {result_q, walk[i]};
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      vn_reg    = VN_RESET;
      key_hash  = FNV_OFFSET;
      ring_cnt  = 0;
      slot_mask = '0;
      result_q.delete();
      fail_o    = 0;
      checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) route_step(in_data_i);
      if (cfg_we_i) vn_reg = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected: %0h", out_data_i);
          fail_o++;
        end else begin
          e = result_q.pop_front();
          checked_o++;
          check_field("kind", 16'(e.kind), 16'(out_data_i.kind));
          check_field("status", 16'(e.status), 16'(out_data_i.status));
          check_field("found", 16'(e.found), 16'(out_data_i.found));
          check_field("node", 16'(e.node), 16'(out_data_i.node));
          check_field("last_result", 16'(e.last_result), 16'(out_data_i.last_result));
          check_field("node_total", 16'(e.node_total), 16'(out_data_i.node_total));
          check_field("present_mask", e.present_mask, out_data_i.present_mask);
        end
      end
    end
    pending_o = result_q.size();
  end

endmodule

// ===== tb/consistent_hash_ring_router_tb.sv =====
// Testbench top for the consistent-hash ring router: clock, reset, stimulus and verdict.
// Depends on chr_pkg, the router and consistent_hash_ring_router_chk.
module consistent_hash_ring_router_tb;
  import chr_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_t            out_data;
  logic            cfg_we = 1'b0;
  logic [VN_W-1:0] cfg_wdata = VN_RESET;
  int              fail_cnt, pending, checked;

  int          n_items = 0;
  bit          calm = 1'b0;
  bit          pres [16];
  logic [7:0]  names [16][8];
  int          name_len [16];
  logic [7:0]  str_q[$];

  always #5 clk_i = ~clk_i;

  consistent_hash_ring_router dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  consistent_hash_ring_router_chk chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_o(fail_cnt), .pending_o(pending), .checked_o(checked)
  );

  function automatic in_t item(input logic [1:0] c, input logic [7:0] b, input logic bv,
                               input logic lst, input logic [3:0] s, input logic [4:0] w);
    in_t t;
    t.cmd = c;
    t.data_byte = b;
    t.byte_valid = bv;
    t.last_byte = lst;
    t.node_slot = s;
    t.replica_count = w;
    return t;
  endfunction

  task automatic send(input in_t t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= t;
    #1;
    while (in_stall) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    @(negedge clk_i);
    n_items++;
  endtask

  task automatic rand_str(input int len);
    str_q.delete();
    repeat (len) str_q = {str_q, 8'($urandom_range(0, 255))};
  endtask

  task automatic stream(input logic [1:0] c, input logic [3:0] s, input logic [4:0] w);
    if (str_q.size() == 0) begin
      send(item(c, 8'($urandom), 1'b0, 1'b1, s, w));
    end else begin
      foreach (str_q[i]) begin
        if ($urandom_range(0, 9) == 0)
          send(item(2'($urandom_range(0, 2)), 8'($urandom), 1'b0, 1'b0, 4'($urandom),
                    5'($urandom_range(0, 16))));
        if (i == str_q.size() - 1) send(item(c, str_q[i], 1'b1, 1'b1, s, w));
        else send(item(2'($urandom_range(0, 2)), str_q[i], 1'b1, 1'b0, 4'($urandom),
                       5'($urandom_range(0, 16))));
      end
    end
  endtask

  task automatic save_name(input int s);
    name_len[s] = str_q.size();
    foreach (str_q[i]) names[s][i] = str_q[i];
  endtask

  task automatic load_name(input int s);
    str_q.delete();
    for (int i = 0; i < name_len[s]; i++) str_q = {str_q, names[s][i]};
  endtask

  task automatic join_slot(input int s);
    if (pres[s] && $urandom_range(0, 1)) begin
      load_name(s);
    end else begin
      rand_str($urandom_range(1, 6));
      if (!pres[s]) save_name(s);
    end
    stream(CMD_ADD, 4'(s), 5'($urandom_range(0, 16)));
    pres[s] = 1'b1;
  endtask

  task automatic leave_slot(input int s);
    if (pres[s] && $urandom_range(0, 9) < 8) load_name(s);
    else rand_str($urandom_range(0, 6));
    stream(CMD_REMOVE, 4'(s), 5'($urandom_range(0, 16)));
    pres[s] = 1'b0;
  endtask

  task automatic drain_nodes();
    for (int s = 0; s < 16; s++) begin
      if (pres[s]) begin
        load_name(s);
        stream(CMD_REMOVE, 4'(s), 5'($urandom_range(0, 16)));
        pres[s] = 1'b0;
      end
    end
  endtask

  task automatic write_vnodes(input logic [VN_W-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [VN_W-1:0] v, input int count, input int slot_hi);
    int target, r;
    drain_nodes();
    write_vnodes(v);
    target = n_items + count;
    while (n_items < target) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        rand_str($urandom_range(0, 4));
        stream(CMD_LOOKUP, 4'($urandom), 5'($urandom_range(0, 16)));
      end else if (r < 70) begin
        join_slot($urandom_range(0, slot_hi));
      end else if (r < 90) begin
        leave_slot($urandom_range(0, slot_hi));
      end else begin
        send(item(CMD_NOP, 8'($urandom), 1'($urandom), 1'($urandom), 4'($urandom),
                  5'($urandom_range(0, 16))));
      end
    end
  endtask

  initial begin
    int k;
    forever begin
      k = calm ? 0 : $urandom_range(0, 16);
      repeat (k) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      #1;
      while (!out_valid) begin
        @(negedge clk_i);
        #1;
      end
      @(posedge clk_i);
    end
  end

  initial begin
    #100000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty ring, empty name, byte extremes, duplicate, want extremes, absent remove
    str_q = '{8'h6b};
    stream(CMD_LOOKUP, 4'd0, 5'd3);
    str_q.delete();
    stream(CMD_ADD, 4'd0, 5'd0);
    pres[0] = 1'b1;
    save_name(0);
    str_q = '{8'h00, 8'hff, 8'h41};
    stream(CMD_ADD, 4'd15, 5'd16);
    pres[15] = 1'b1;
    save_name(15);
    stream(CMD_ADD, 4'd15, 5'd0);
    str_q = '{8'hff};
    stream(CMD_LOOKUP, 4'd9, 5'd16);
    stream(CMD_LOOKUP, 4'd9, 5'd0);
    str_q.delete();
    stream(CMD_LOOKUP, 4'd5, 5'd1);
    str_q = '{8'h80, 8'h01};
    stream(CMD_REMOVE, 4'd7, 5'd2);
    send(item(CMD_NOP, 8'h55, 1'b1, 1'b1, 4'd3, 5'd4));
    load_name(15);
    stream(CMD_REMOVE, 4'd15, 5'd8);
    pres[15] = 1'b0;
    str_q = '{8'h12, 8'h34};
    stream(CMD_LOOKUP, 4'd0, 5'd2);

    run_phase(7'd1, 120, 15);
    run_phase(7'd64, 35, 3);
    run_phase(7'd0, 40, 15);
    run_phase(7'd127, 25, 3);
    run_phase(7'($urandom_range(2, 12)), 450 - n_items, 15);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Covered %0d input transactions and %0d checked results", n_items, checked);
    $display("over virtual node settings 16, 1, 64, 0, 127 and a random one.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== consistent_hash_ring_router.f =====
src/chr_pkg.sv
src/chr_front.sv
src/chr_fifo.sv
src/chr_back.sv
src/consistent_hash_ring_router.sv
tb/consistent_hash_ring_router_chk.sv
tb/consistent_hash_ring_router_tb.sv
